>>> rtl/tfic_pkg.sv
// Shared types, constants and helpers of the firmware image checker.
`default_nettype none

package tfic_pkg;

    localparam int unsigned HDR_BYTES = 88;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned CNT_W     = 22;
    localparam int unsigned SUM_W     = 25;
    localparam int unsigned ERR_W     = 2;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = 2;
    localparam int unsigned QCNT_W    = 3;
    localparam int unsigned OUT_W     = 208;

    localparam logic [31:0]      MAGIC   = 32'h0a4c5749;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ONE   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TWO   = 2'd2;

    localparam logic [31:0] TYPE_API = 32'd29;

    // record classes
    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_CODE  = 2'd1,
        CLS_DATA  = 2'd2,
        CLS_META  = 2'd3
    } t_class;

    // what a byte is, by its place in the image
    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_VER   = 3'd1,
        K_BLD   = 3'd2,
        K_HDR   = 3'd3,
        K_HEND  = 3'd4,
        K_BODY  = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_kind      kind;
        logic [2:0] idx;
    } t_tag;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_RHEAD   = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_PAD     = 5'b01000,
        PH_BAD     = 5'b10000
    } t_phase;

    function automatic t_class classify(input logic [31:0] t);
        t_class c;
        c = CLS_OTHER;
        if (t == 32'd1 || t == 32'd3 || t == 32'd5 || t == 32'd16 ||
            (t >= 32'd19 && t <= 32'd21) || (t >= 32'd24 && t <= 32'd26)) begin
            c = CLS_CODE;
        end else if (t == 32'd2 || t == 32'd4 || t == 32'd17) begin
            c = CLS_DATA;
        end else if (t == 32'd29 || t == 32'd30) begin
            c = CLS_META;
        end
        return c;
    endfunction

    // expected value of the leading bytes: zero word, then the magic
    function automatic logic [7:0] start_byte(input logic [2:0] i);
        logic [63:0] w;
        w = {MAGIC, 32'd0};
        return w[8*i +: 8];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : CNT_W'(v + 1'b1);
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] v,
                                                 input logic [31:0] a);
        logic [SUM_W:0] s;
        s = {1'b0, v} + {1'b0, a[SUM_W-1:0]};
        return (a[31:SUM_W] != '0 || s[SUM_W]) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/tlv_firmware_image_checker_unit.sv
// Top level of the firmware image checker: front end, queue and back end.
//
// channel   dir   handshake                    payload
// s         in    i_s_tvalid / o_s_tready      i_s_tdata = data_byte, i_s_tlast = last_byte
// m         out   o_m_tvalid / i_m_tready      o_m_tdata = validation report
//
// One image byte per cycle while the queue has room; the back end retires one queued word
// per cycle unless a report waits. A final byte passes the queue, then the report register.
// The front end stalls only when the four-entry queue is full; the back end stalls only
// while a report waits in its register.
// Reset is synchronous, active low; after each report the parser restarts on its own.
`default_nettype none

module tlv_firmware_image_checker_unit
    import tfic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tlast,   // last_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] image_valid, [32:1] fw_version, [64:33] fw_build, [86:65] record_count,
    // [108:87] section_count, [130:109] api_count, [152:131] capa_count,
    // [177:153] code_bytes, [202:178] data_bytes_total, [204:203] error_count, rest 0
    output logic [OUT_W-1:0] o_m_tdata
);

    logic w_push;
    t_tag w_in_tag;
    logic w_q_ready;
    logic w_q_valid;
    t_tag w_q_tag;
    logic w_pop;

    tfic_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_data    (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_ready   (o_s_tready),
        .o_push    (w_push),
        .o_tag     (w_in_tag),
        .i_q_ready (w_q_ready)
    );

    tfic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tag   (w_in_tag),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_tag   (w_q_tag),
        .i_pop   (w_pop)
    );

    tfic_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_tag     (w_q_tag),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .o_data    (o_m_tdata),
        .i_ready   (i_m_tready)
    );

endmodule

`default_nettype wire

>>> rtl/tfic_front.sv
// Front end: accepts image bytes and tags each one with its place in the header.
`default_nettype none

module tfic_front
    import tfic_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    output logic            o_ready,
    output logic            o_push,
    output t_tag            o_tag,
    input  wire logic       i_q_ready
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             w_acc;

    assign o_ready = i_q_ready;
    assign w_acc   = i_valid && i_q_ready;
    assign o_push  = w_acc;

    always_comb begin
        n_pos = r_pos;
        if (w_acc) begin
            if (i_last) begin
                n_pos = '0;
            end else if (r_pos < POS_W'(HDR_BYTES)) begin
                n_pos = POS_W'(r_pos + 1'b1);
            end
        end
    end

    always_comb begin
        o_tag.data = i_data;
        o_tag.last = i_last;
        o_tag.idx  = r_pos[2:0];
        priority if (r_pos < POS_W'(8)) begin
            o_tag.kind = K_START;
        end else if (r_pos >= POS_W'(72) && r_pos < POS_W'(76)) begin
            o_tag.kind = K_VER;
        end else if (r_pos >= POS_W'(76) && r_pos < POS_W'(80)) begin
            o_tag.kind = K_BLD;
        end else if (r_pos == POS_W'(HDR_BYTES - 1)) begin
            o_tag.kind = K_HEND;
        end else if (r_pos < POS_W'(HDR_BYTES)) begin
            o_tag.kind = K_HDR;
        end else begin
            o_tag.kind = K_BODY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tfic_queue.sv
// Short queue of tagged words between the front and back ends.
`default_nettype none

module tfic_queue
    import tfic_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_tag      i_tag,
    output logic      o_ready,
    output logic      o_valid,
    output t_tag      o_tag,
    input  wire logic i_pop
);

    t_tag              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tag   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    property p_no_over;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == QCNT_W'(QDEPTH)) |-> !i_push || i_pop;
    endproperty
    a_no_over: assert property (p_no_over) else $error("queue overrun");

    property p_no_under;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !i_pop;
    endproperty
    a_no_under: assert property (p_no_under) else $error("queue underrun");

    property p_cnt_step;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == QCNT_W'($past(r_cnt) + 1'b1));
    endproperty
    a_cnt_step: assert property (p_cnt_step) else $error("queue count slip");

endmodule

`default_nettype wire

>>> rtl/tfic_back.sv
// Back end: record parser, tallies and the report register.
`default_nettype none

module tfic_back
    import tfic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_tag             i_tag,
    output logic             o_pop,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_data,
    input  wire logic        i_ready
);

    t_phase           r_phase, n_phase;
    logic             r_start_ok, n_start_ok;
    logic [31:0]      r_ver, n_ver;
    logic [31:0]      r_bld, n_bld;
    logic [31:0]      r_type, n_type;
    logic [31:0]      r_len, n_len;
    logic [2:0]       r_hidx, n_hidx;
    logic [31:0]      r_left, n_left;
    logic [1:0]       r_pad, n_pad;
    logic [CNT_W-1:0] r_rec, n_rec;
    logic [CNT_W-1:0] r_sec, n_sec;
    logic [CNT_W-1:0] r_api, n_api;
    logic [CNT_W-1:0] r_capa, n_capa;
    logic [SUM_W-1:0] r_code, n_code;
    logic [SUM_W-1:0] r_dsum, n_dsum;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out, n_out;

    logic             w_count;
    logic             w_add_len;
    logic [31:0]      w_full_len;
    logic [31:0]      w_add;
    t_class           w_cls;
    logic             w_hdr_ok;
    logic [ERR_W-1:0] w_err;

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign w_full_len = {i_tag.data, r_len[23:0]};
    assign w_cls      = classify(r_type);
    assign w_add      = w_add_len ? r_len : 32'd0;

    always_comb begin
        n_phase    = r_phase;
        n_start_ok = r_start_ok;
        n_ver      = r_ver;
        n_bld      = r_bld;
        n_type     = r_type;
        n_len      = r_len;
        n_hidx     = r_hidx;
        n_left     = r_left;
        n_pad      = r_pad;
        n_rec      = r_rec;
        n_sec      = r_sec;
        n_api      = r_api;
        n_capa     = r_capa;
        n_code     = r_code;
        n_dsum     = r_dsum;
        w_count    = 1'b0;
        w_add_len  = 1'b0;

        if (o_pop) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_tag.kind == K_VER) begin
                        n_ver = {i_tag.data, r_ver[31:8]};
                    end
                    if (i_tag.kind == K_BLD) begin
                        n_bld = {i_tag.data, r_bld[31:8]};
                    end
                    if (i_tag.kind == K_START) begin
                        n_start_ok = r_start_ok && (i_tag.data == start_byte(i_tag.idx));
                        if (i_tag.idx == 3'd7 && !n_start_ok) begin
                            n_phase = PH_BAD;
                        end
                    end
                    if (i_tag.kind == K_HEND) begin
                        n_phase = PH_RHEAD;
                    end
                end
                PH_RHEAD: begin
                    if (!r_hidx[2]) begin
                        n_type[8*r_hidx[1:0] +: 8] = i_tag.data;
                    end else begin
                        n_len[8*r_hidx[1:0] +: 8] = i_tag.data;
                    end
                    n_hidx = 3'(r_hidx + 1'b1);
                    if (r_hidx == 3'd7) begin
                        if (w_full_len == 32'd0) begin
                            w_count = 1'b1;
                        end else begin
                            n_left  = w_full_len;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_left = r_left - 32'd1;
                    if (r_left == 32'd1) begin
                        w_count   = 1'b1;
                        w_add_len = 1'b1;
                        n_pad     = 2'(~r_len[1:0] + 2'd1);
                        n_phase   = (r_len[1:0] != 2'd0) ? PH_PAD : PH_RHEAD;
                    end
                end
                PH_PAD: begin
                    n_pad = 2'(r_pad - 1'b1);
                    if (r_pad == 2'd1) begin
                        n_phase = PH_RHEAD;
                    end
                end
                PH_BAD: begin
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase
        end

        // tally a finished record
        if (w_count) begin
            n_rec = cnt_inc(r_rec);
            unique case (w_cls)
                CLS_CODE: begin
                    n_code = sum_add(r_code, w_add);
                    n_sec  = cnt_inc(r_sec);
                end
                CLS_DATA: begin
                    n_dsum = sum_add(r_dsum, w_add);
                    n_sec  = cnt_inc(r_sec);
                end
                CLS_META: begin
                    if (r_type == TYPE_API) begin
                        n_api = cnt_inc(r_api);
                    end else begin
                        n_capa = cnt_inc(r_capa);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // error grading on the final byte, from the state after that byte
    always_comb begin
        w_hdr_ok = 1'b1;
        unique case (n_phase)
            PH_RHEAD:   w_err = (n_hidx != 3'd0) ? ERR_ONE : ERR_NONE;
            PH_PAYLOAD: w_err = (n_left == n_len) ? ERR_ONE : ERR_TWO;
            PH_PAD:     w_err = ERR_TWO;
            default: begin
                w_hdr_ok = 1'b0;
                w_err    = ERR_ONE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_pop && i_tag.last) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out[204:203] = w_err;
            if (w_hdr_ok) begin
                n_out[0]       = (n_rec != '0) && (w_err == ERR_NONE);
                n_out[32:1]    = n_ver;
                n_out[64:33]   = n_bld;
                n_out[86:65]   = n_rec;
                n_out[108:87]  = n_sec;
                n_out[130:109] = n_api;
                n_out[152:131] = n_capa;
                n_out[177:153] = n_code;
                n_out[202:178] = n_dsum;
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_tag.last)) begin
            r_phase    <= PH_HEADER;
            r_start_ok <= 1'b1;
            r_ver      <= '0;
            r_bld      <= '0;
            r_type     <= '0;
            r_len      <= '0;
            r_hidx     <= '0;
            r_left     <= '0;
            r_pad      <= '0;
            r_rec      <= '0;
            r_sec      <= '0;
            r_api      <= '0;
            r_capa     <= '0;
            r_code     <= '0;
            r_dsum     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_start_ok <= n_start_ok;
            r_ver      <= n_ver;
            r_bld      <= n_bld;
            r_type     <= n_type;
            r_len      <= n_len;
            r_hidx     <= n_hidx;
            r_left     <= n_left;
            r_pad      <= n_pad;
            r_rec      <= n_rec;
            r_sec      <= n_sec;
            r_api      <= n_api;
            r_capa     <= n_capa;
            r_code     <= n_code;
            r_dsum     <= n_dsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    property p_valid_no_err;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[204:203] != ERR_NONE) |-> !r_out[0];
    endproperty
    a_valid_no_err: assert property (p_valid_no_err) else $error("valid report with errors");

    property p_err_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out[204:203] != 2'd3);
    endproperty
    a_err_range: assert property (p_err_range) else $error("error count out of range");

    property p_payload_left;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != 32'd0) && (r_len != 32'd0);
    endproperty
    a_payload_left: assert property (p_payload_left) else $error("empty payload phase");

    property p_pad_left;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAD) |-> (r_pad != 2'd0);
    endproperty
    a_pad_left: assert property (p_pad_left) else $error("empty pad phase");

    property p_restart;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_tag.last) |=> (r_phase == PH_HEADER) && r_out_valid && (r_rec == '0);
    endproperty
    a_restart: assert property (p_restart) else $error("no restart after final word");

endmodule

`default_nettype wire
